// ----- design/drbc_pkg.sv -----
// ============================================================================
// drbc_pkg
// Shared widths, codes and control types of the descriptor ring binding cache.
// ============================================================================
package drbc_pkg;

    localparam int CFG_W       = 9;
    localparam int HEAP_IDX_W  = 4;
    localparam int ELEM_W      = 8;
    localparam int SLOT_OUT_W  = 8;
    localparam int STATUS_W    = 2;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic CMD_CREATE = 1'b0;
    localparam logic CMD_BIND   = 1'b1;

    localparam logic REG_RING_SIZE = 1'b0;
    localparam logic REG_HEAP_SIZE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_UNKNOWN  = 2'd2
    } t_status;

    typedef struct packed {
        t_status                 status;
        logic                    hit;
        logic [HEAP_IDX_W-1:0]   heap_index;
        logic [ELEM_W-1:0]       element_index;
        logic [SLOT_OUT_W-1:0]   ring_slot;
    } t_rsp;

    typedef struct packed {
        logic load_in;
        logic read;
        logic eval;
        logic link;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic read_final;
        logic eval_hit;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- design/drbc_req_if.sv -----
// ============================================================================
// drbc_req_if
// Request channel: command and view coordinates with valid/ready.
// ============================================================================
interface drbc_req_if import drbc_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [HEAP_IDX_W-1:0] view_heap;
    logic [ELEM_W-1:0]     view_element;

    modport source (output valid, output command, output view_heap, output view_element,
                    input ready);
    modport sink   (input valid, input command, input view_heap, input view_element,
                    output ready);

endinterface

// ----- design/drbc_rsp_if.sv -----
// ============================================================================
// drbc_rsp_if
// Response channel: status, hit flag, created coordinates and ring slot.
// ============================================================================
interface drbc_rsp_if import drbc_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic                  hit;
    logic [HEAP_IDX_W-1:0] heap_index;
    logic [ELEM_W-1:0]     element_index;
    logic [SLOT_OUT_W-1:0] ring_slot;

    modport source (output valid, output status, output hit, output heap_index,
                    output element_index, output ring_slot, input ready);
    modport sink   (input valid, input status, input hit, input heap_index,
                    input element_index, input ring_slot, output ready);

endinterface

// ----- design/descriptor_ring_binding_cache.sv -----
// ============================================================================
// descriptor_ring_binding_cache
// Allocates views into backing heaps and binds them into a FIFO ring of slots.
// ============================================================================
// Request channel i_req carries command (create or bind), view_heap and
// view_element; response channel o_rsp returns status, hit, heap_index,
// element_index and ring_slot, one response per request, in order.
// Configuration: APB registers ring_size (address 0) and heap_size (address 4),
// both resetting to 256 and clamped to the built depths; write them only while
// no request is in flight.
// One request is processed at a time. A create or a failed bind ends after the
// read step, a bind hit after the evaluate step and a bind miss after the link
// step, set by the single read port of the view table (look up, evict the old
// occupant, link the new one). The next request is accepted the cycle after the
// response is loaded, even if it is not yet taken.
// Reset empties the ring and closes all heaps; view table contents are only
// defined once a create writes them. When the receiver stalls, the response
// holds in the output register and the sequencer waits to load the next one.
// ============================================================================
module descriptor_ring_binding_cache import drbc_pkg::*; #(
    parameter int RING_DEPTH = 256,
    parameter int HEAP_SLOTS = 256,
    parameter int MAX_HEAPS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    drbc_req_if.sink              i_req,
    drbc_rsp_if.source            o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] r_ring_size;
    logic [CFG_W-1:0] r_heap_size;
    t_dp_cmd          cmd;
    t_dp_stat         stat;
    t_rsp             out;
    logic             out_valid;
    logic             in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= CFG_RESET;
            r_heap_size <= CFG_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[REG_SEL_BIT])
                REG_RING_SIZE: r_ring_size <= pwdata[CFG_W-1:0];
                REG_HEAP_SIZE: r_heap_size <= pwdata[CFG_W-1:0];
                default:       r_ring_size <= r_ring_size;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[REG_SEL_BIT])
            REG_RING_SIZE: prdata = APB_DATA_W'(r_ring_size);
            REG_HEAP_SIZE: prdata = APB_DATA_W'(r_heap_size);
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    drbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    drbc_dp #(
        .RING_DEPTH (RING_DEPTH),
        .HEAP_SLOTS (HEAP_SLOTS),
        .MAX_HEAPS  (MAX_HEAPS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ring_size    (r_ring_size),
        .i_heap_size    (r_heap_size),
        .i_command      (i_req.command),
        .i_view_heap    (i_req.view_heap),
        .i_view_element (i_req.view_element),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (out_valid),
        .o_out          (out),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

    assign i_req.ready         = in_ready;
    assign o_rsp.valid         = out_valid;
    assign o_rsp.status        = out.status;
    assign o_rsp.hit           = out.hit;
    assign o_rsp.heap_index    = out.heap_index;
    assign o_rsp.element_index = out.element_index;
    assign o_rsp.ring_slot     = out.ring_slot;

endmodule

// ----- design/drbc_ctrl.sv -----
// ============================================================================
// drbc_ctrl
// Sequencer: steps one item through read, then evaluate and link as needed, and emit.
// ============================================================================
module drbc_ctrl import drbc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EVAL = 5'b00100,
        S_LINK = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = i_stat.read_final ? S_DONE : S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.eval_hit ? S_DONE : S_LINK;
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- design/drbc_dp.sv -----
// ============================================================================
// drbc_dp
// Datapath: heap allocation, view-to-slot and slot-to-view tables, FIFO ring
// pointer and output register.
// ============================================================================
module drbc_dp import drbc_pkg::*; #(
    parameter int RING_DEPTH = 256,
    parameter int HEAP_SLOTS = 256,
    parameter int MAX_HEAPS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CFG_W-1:0]      i_ring_size,
    input  logic [CFG_W-1:0]      i_heap_size,
    input  logic                  i_command,
    input  logic [HEAP_IDX_W-1:0] i_view_heap,
    input  logic [ELEM_W-1:0]     i_view_element,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_rsp                  o_out,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int HWM_W  = $clog2(RING_DEPTH + 1);
    localparam int VIEWS  = MAX_HEAPS * HEAP_SLOTS;
    localparam int VIEW_W = (VIEWS > 1) ? $clog2(VIEWS) : 1;
    localparam int HO_W   = $clog2(MAX_HEAPS + 1);
    localparam int SOV_W  = SLOT_W + 1;

    logic                  r_command;
    logic [HEAP_IDX_W-1:0] r_view_heap;
    logic [ELEM_W-1:0]     r_view_element;
    logic [HO_W-1:0]       r_heaps;
    logic [CFG_W-1:0]      r_fill;
    logic [SLOT_W-1:0]     r_ptr;
    logic [HWM_W-1:0]      r_hwm;
    logic [VIEW_W-1:0]     r_view;
    logic [SLOT_W-1:0]     r_p;
    t_rsp                  r_res;
    t_rsp                  r_out;
    logic                  r_out_valid;

    logic [SOV_W-1:0]      r_sov_mem [VIEWS];
    logic [SOV_W-1:0]      r_sov_rd;
    logic [VIEW_W-1:0]     r_vis_mem [RING_DEPTH];
    logic [VIEW_W-1:0]     r_vis_rd;

    logic [CFG_W-1:0]      heap_eff;
    logic [CFG_W-1:0]      ring_eff;
    logic                  need_new;
    logic                  no_space;
    logic [HO_W-1:0]       cr_heap;
    logic [CFG_W-1:0]      cr_elem;
    logic [VIEW_W-1:0]     cr_view;
    logic                  exists;
    logic [VIEW_W-1:0]     bind_view;
    logic [SLOT_W-1:0]     p_sel;
    logic                  evict_valid;
    t_rsp                  res_read;
    logic                  sov_we;
    logic [VIEW_W-1:0]     sov_wa;
    logic [SOV_W-1:0]      sov_wd;
    logic                  vis_we;

    always_comb begin
        heap_eff = i_heap_size;
        if (i_heap_size == '0) begin
            heap_eff = CFG_W'(1);
        end else if (32'(i_heap_size) > 32'(HEAP_SLOTS)) begin
            heap_eff = CFG_W'(HEAP_SLOTS);
        end
        ring_eff = i_ring_size;
        if (i_ring_size == '0) begin
            ring_eff = CFG_W'(1);
        end else if (32'(i_ring_size) > 32'(RING_DEPTH)) begin
            ring_eff = CFG_W'(RING_DEPTH);
        end
    end

    // create placement
    always_comb begin
        need_new = (r_heaps == '0) || (r_fill >= heap_eff);
        no_space = need_new && (32'(r_heaps) >= 32'(MAX_HEAPS));
        cr_heap  = need_new ? r_heaps : r_heaps - 1'b1;
        cr_elem  = need_new ? '0 : r_fill;
        cr_view  = VIEW_W'(32'(cr_heap) * 32'(HEAP_SLOTS) + 32'(cr_elem));
    end

    // bind lookup
    always_comb begin
        if (32'(r_view_heap) >= 32'(r_heaps)) begin
            exists = 1'b0;
        end else if (32'(r_view_heap) + 32'd1 == 32'(r_heaps)) begin
            exists = 32'(r_view_element) < 32'(r_fill);
        end else begin
            exists = 32'(r_view_element) < 32'(heap_eff);
        end
        bind_view   = VIEW_W'(32'(r_view_heap) * 32'(HEAP_SLOTS) + 32'(r_view_element));
        p_sel       = (32'(r_ptr) >= 32'(ring_eff)) ? '0 : r_ptr;
        evict_valid = 32'(r_p) < 32'(r_hwm);
    end

    always_comb begin
        res_read = '{status: ST_UNKNOWN, hit: 1'b0, heap_index: '0,
                     element_index: '0, ring_slot: '0};
        if (r_command == CMD_CREATE) begin
            if (no_space) begin
                res_read.status = ST_NO_SPACE;
            end else begin
                res_read.status        = ST_OK;
                res_read.heap_index    = HEAP_IDX_W'(cr_heap);
                res_read.element_index = ELEM_W'(cr_elem);
            end
        end
    end

    assign o_stat.read_final = (r_command == CMD_CREATE) || !exists;
    assign o_stat.eval_hit   = r_sov_rd[SLOT_W];
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        sov_we = 1'b0;
        sov_wa = r_view;
        sov_wd = {1'b1, r_p};
        if (i_cmd.read && (r_command == CMD_CREATE) && !no_space) begin
            sov_we = 1'b1;
            sov_wa = cr_view;
            sov_wd = '0;
        end else if (i_cmd.eval && !r_sov_rd[SLOT_W] && evict_valid) begin
            sov_we = 1'b1;
            sov_wa = r_vis_rd;
            sov_wd = '0;
        end else if (i_cmd.link) begin
            sov_we = 1'b1;
        end
        vis_we = i_cmd.eval && !r_sov_rd[SLOT_W];
    end

    always_ff @(posedge i_clk) begin
        if (sov_we) begin
            r_sov_mem[sov_wa] <= sov_wd;
        end
        if (i_cmd.read) begin
            r_sov_rd <= r_sov_mem[bind_view];
        end
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_vis_mem[r_p] <= r_view;
        end
        if (i_cmd.read) begin
            r_vis_rd <= r_vis_mem[p_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_command      <= i_command;
            r_view_heap    <= i_view_heap;
            r_view_element <= i_view_element;
        end
        if (i_cmd.read) begin
            r_view <= bind_view;
            r_p    <= p_sel;
            r_res  <= res_read;
        end
        if (i_cmd.eval) begin
            r_res <= '{status: ST_OK, hit: 1'b1, heap_index: '0, element_index: '0,
                       ring_slot: SLOT_OUT_W'(r_sov_rd[SLOT_W-1:0])};
        end
        if (i_cmd.link) begin
            r_res <= '{status: ST_OK, hit: 1'b0, heap_index: '0, element_index: '0,
                       ring_slot: SLOT_OUT_W'(r_p)};
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heaps     <= '0;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_hwm       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.read && (r_command == CMD_CREATE) && !no_space) begin
                if (need_new) begin
                    r_heaps <= r_heaps + 1'b1;
                    r_fill  <= CFG_W'(1);
                end else begin
                    r_fill  <= r_fill + 1'b1;
                end
            end
            if (i_cmd.link) begin
                r_ptr <= (32'(r_p) + 32'd1 >= 32'(ring_eff)) ? '0 : r_p + 1'b1;
                if (!evict_valid) begin
                    r_hwm <= r_hwm + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_link_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.link |-> (32'(r_p) <= 32'(r_hwm)))
        else $error("victim slot beyond filled prefix of the ring");

    a_ptr_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.link |=> ((r_ptr == '0) || (r_ptr == $past(r_p) + 1'b1)))
        else $error("ring pointer did not advance past the victim");

    a_heaps_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_heaps != $past(r_heaps)))
            |-> ((r_heaps == $past(r_heaps) + 1'b1) && $past(i_cmd.read)))
        else $error("heap count changed outside a create");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(HEAP_SLOTS))
        else $error("heap fill beyond heap capacity");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> $past(i_cmd.emit))
        else $error("output became valid without an emit");

endmodule

// ----- sim/descriptor_ring_binding_cache_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// descriptor_ring_binding_cache_test
// Self-checking bench for the descriptor ring binding cache: creates and binds
// are driven on the request channel, each accepted request is run through a
// behavioral model of the heaps and the FIFO ring, and every response is
// compared field by field in order. Ring and heap sizes are swept over their
// extremes through the APB port while the block is idle.
// ============================================================================
module descriptor_ring_binding_cache_test;
    import drbc_pkg::*;

    localparam int RING_DEPTH = 256;
    localparam int HEAP_SLOTS = 256;
    localparam int MAX_HEAPS  = 16;
    localparam int VIEW_COUNT = MAX_HEAPS * HEAP_SLOTS;
    localparam logic [8:0] UNBOUND = 9'd256;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    drbc_req_if req_if ();
    drbc_rsp_if rsp_if ();

    descriptor_ring_binding_cache uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [8:0]  ring_size_reg;
    logic [8:0]  heap_size_reg;
    logic [8:0]  bound_slot [VIEW_COUNT];
    logic        slot_used  [RING_DEPTH];
    logic [11:0] slot_owner [RING_DEPTH];
    int unsigned next_victim;
    int unsigned heaps_open;
    int unsigned last_fill;

    t_rsp pending_rsps [$];
    int   mismatch_count;
    bit   src_idle;
    bit   snk_idle;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        rsp_if.ready <= !snk_idle || ($urandom_range(99) >= 28);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsps.size() == 0) begin
                report_mismatch("unexpected response", 1, 0);
            end else begin
                want = pending_rsps.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch("status", int'(rsp_if.status), int'(want.status));
                if (rsp_if.hit !== want.hit)
                    report_mismatch("hit", int'(rsp_if.hit), int'(want.hit));
                if (rsp_if.heap_index !== want.heap_index)
                    report_mismatch("heap_index", int'(rsp_if.heap_index),
                                    int'(want.heap_index));
                if (rsp_if.element_index !== want.element_index)
                    report_mismatch("element_index", int'(rsp_if.element_index),
                                    int'(want.element_index));
                if (rsp_if.ring_slot !== want.ring_slot)
                    report_mismatch("ring_slot", int'(rsp_if.ring_slot), int'(want.ring_slot));
            end
        end
    end

    function automatic int unsigned clamp_cfg(input logic [8:0] v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic t_rsp predict_binding(input logic cmd, input logic [3:0] vh,
                                             input logic [7:0] ve);
        t_rsp        rsp;
        int unsigned heap_eff;
        int unsigned ring_eff;
        int unsigned victim;
        logic        exists;
        logic [11:0] view;
        rsp        = '0;
        rsp.status = ST_OK;
        heap_eff   = clamp_cfg(heap_size_reg, HEAP_SLOTS);
        ring_eff   = clamp_cfg(ring_size_reg, RING_DEPTH);
        if (cmd == CMD_CREATE) begin
            if (heaps_open == 0 || last_fill >= heap_eff) begin
                if (heaps_open >= MAX_HEAPS) begin
                    rsp.status = ST_NO_SPACE;
                    return rsp;
                end
                heaps_open++;
                last_fill = 0;
            end
            rsp.heap_index    = 4'(heaps_open - 1);
            rsp.element_index = 8'(last_fill);
            bound_slot[{rsp.heap_index, rsp.element_index}] = UNBOUND;
            last_fill++;
            return rsp;
        end
        if (vh >= heaps_open) exists = 1'b0;
        else if (vh + 1 == heaps_open) exists = (ve < last_fill);
        else exists = (ve < heap_eff);
        if (!exists) begin
            rsp.status = ST_UNKNOWN;
            return rsp;
        end
        view = {vh, ve};
        if (bound_slot[view] < RING_DEPTH) begin
            rsp.hit       = 1'b1;
            rsp.ring_slot = bound_slot[view][7:0];
            return rsp;
        end
        victim = (next_victim >= ring_eff) ? 0 : next_victim;
        if (slot_used[victim]) bound_slot[slot_owner[victim]] = UNBOUND;
        bound_slot[view]   = 9'(victim);
        slot_owner[victim] = view;
        slot_used[victim]  = 1'b1;
        next_victim        = (victim + 1 >= ring_eff) ? 0 : victim + 1;
        rsp.ring_slot      = 8'(victim);
        return rsp;
    endfunction

    task automatic send_request(input logic cmd, input logic [HEAP_IDX_W-1:0] vh,
                                input logic [ELEM_W-1:0] ve);
        t_rsp want_rsp;
        if (src_idle) begin
            while ($urandom_range(99) < 28) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_if.valid        <= 1'b1;
        req_if.command      <= cmd;
        req_if.view_heap    <= vh;
        req_if.view_element <= ve;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        want_rsp     = predict_binding(cmd, vh, ve);
        pending_rsps = {pending_rsps, want_rsp};
    endtask

    task automatic settle_until_idle();
        req_if.valid <= 1'b0;
        while (pending_rsps.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(reg_sel) << REG_SEL_BIT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_RING_SIZE) ring_size_reg = value[8:0];
        else heap_size_reg = value[8:0];
    endtask

    // bias toward low elements so binds revisit views and hit
    task automatic send_known_bind();
        int unsigned h;
        int unsigned lim;
        if (heaps_open == 0) begin
            send_request(CMD_BIND, 4'($urandom), 8'($urandom));
            return;
        end
        h   = $urandom_range(heaps_open - 1);
        lim = (h == heaps_open - 1) ? last_fill : clamp_cfg(heap_size_reg, HEAP_SLOTS);
        if (lim > 12 && $urandom_range(1) == 1) lim = 12;
        send_request(CMD_BIND, h[3:0], 8'($urandom_range(lim - 1)));
    endtask

    task automatic run_random(input int count, input int create_pct);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 12) send_request(1'($urandom), 4'($urandom), 8'($urandom));
            else if (r < 12 + create_pct * 88 / 100)
                send_request(CMD_CREATE, 4'($urandom), 8'($urandom));
            else send_known_bind();
            if ($urandom_range(49) == 0) settle_until_idle();
        end
    endtask

    task automatic test_create_bind_basics();
        write_register(REG_RING_SIZE, 32'd511);
        write_register(REG_HEAP_SIZE, 32'd511);
        send_request(CMD_BIND, 4'd0, 8'd0);
        send_request(CMD_BIND, 4'd15, 8'd255);
        send_request(CMD_CREATE, 4'd0, 8'd0);
        send_request(CMD_BIND, 4'd0, 8'd0);
        send_request(CMD_BIND, 4'd0, 8'd0);
        send_request(CMD_BIND, 4'd0, 8'd1);
        send_request(CMD_BIND, 4'd1, 8'd0);
        send_request(CMD_CREATE, 4'd15, 8'd255);
        send_request(CMD_CREATE, 4'd0, 8'd0);
        send_request(CMD_CREATE, 4'd0, 8'd0);
        send_request(CMD_BIND, 4'd0, 8'd3);
        send_request(CMD_BIND, 4'd0, 8'd2);
        send_request(CMD_BIND, 4'd0, 8'd3);
        send_request(CMD_BIND, 4'd0, 8'd4);
        settle_until_idle();
    endtask

    task automatic test_wide_ring_random();
        write_register(REG_RING_SIZE, 32'd256);
        write_register(REG_HEAP_SIZE, 32'd256);
        run_random(260, 45);
        settle_until_idle();
    endtask

    task automatic test_ring_size_sweep();
        logic [8:0] sizes [5] = '{9'd2, 9'd0, 9'd1, 9'd7, 9'd300};
        foreach (sizes[k]) begin
            write_register(REG_RING_SIZE, 32'(sizes[k]));
            if (k == 3) begin
                src_idle = 1'b0;
                snk_idle = 1'b0;
            end
            if (k == 0) repeat (4) send_known_bind();
            run_random(45, 20);
            settle_until_idle();
        end
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    task automatic test_heap_shrink();
        write_register(REG_RING_SIZE, 32'd16);
        write_register(REG_HEAP_SIZE, 32'd3);
        run_random(150, 40);
        settle_until_idle();
    endtask

    task automatic test_heap_exhaustion();
        write_register(REG_HEAP_SIZE, 32'd0);
        write_register(REG_RING_SIZE, 32'd256);
        while (heaps_open < MAX_HEAPS || last_fill < clamp_cfg(heap_size_reg, HEAP_SLOTS))
            send_request(CMD_CREATE, 4'd0, 8'd0);
        send_request(CMD_CREATE, 4'd15, 8'd255);
        send_request(CMD_BIND, 4'd15, 8'd2);
        send_request(CMD_BIND, 4'd14, 8'd2);
        send_request(CMD_BIND, 4'd0, 8'd0);
        settle_until_idle();
        write_register(REG_HEAP_SIZE, 32'd1);
        run_random(115, 25);
        settle_until_idle();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_if.valid        = 1'b0;
        req_if.command      = CMD_CREATE;
        req_if.view_heap    = '0;
        req_if.view_element = '0;
        rsp_if.ready        = 1'b0;
        src_idle            = 1'b1;
        snk_idle            = 1'b1;
        mismatch_count      = 0;
        ring_size_reg       = CFG_RESET;
        heap_size_reg       = CFG_RESET;
        next_victim         = 0;
        heaps_open          = 0;
        last_fill           = 0;
        foreach (slot_used[s]) slot_used[s] = 1'b0;
        foreach (slot_owner[s]) slot_owner[s] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_create_bind_basics();
        test_wide_ring_random();
        test_ring_size_sweep();
        test_heap_shrink();
        test_heap_exhaustion();

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_rsps.size() == 0) begin
            $display("descriptor_ring_binding_cache verification clean");
        end else begin
            $display("descriptor_ring_binding_cache verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("descriptor_ring_binding_cache verification failed");
        $finish;
    end

endmodule
